// ----- design/wsi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsi_pkg
// Shared widths, types and command/status bundles of the waypoint
// segment interpolator.
// ----------------------------------------------------------------------------
package wsi_pkg;

  // Coordinate width (two's complement Q15.16 at the default).
  localparam int CoordBits = 32;
  localparam int NumAxes   = 3;
  // Width of the inserted-point count; the divisor N + 1 takes one bit more.
  localparam int NBits     = 6;
  localparam int DivBits   = NBits + 1;
  // Step counter covers the divider iterations and the inserted points.
  localparam int CntBits   = ($clog2(CoordBits) > NBits) ? $clog2(CoordBits) : NBits;

  localparam logic [NBits-1:0] PointsBetweenReset = NBits'(10);

  typedef logic [CoordBits-1:0] coord_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // capture a new point and load the divider
    logic div_step;     // one restoring-division iteration on every axis
    logic setup;        // turn quotient/remainder into floor step and fraction
    logic emit_interp;  // advance the position and present an inserted point
    logic emit_last;    // present the new point and make it the previous one
  } wsi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             out_free;  // output register can take an item this cycle
    logic [NBits-1:0] points;    // configured number of inserted points
  } wsi_status_t;

endpackage

// ----- design/wsi_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsi_ctrl
// Sequencer of the interpolator: accepts a point, runs the divider and the
// inserted points with a prior point held and N > 0, then emits the new point.
// ----------------------------------------------------------------------------
module wsi_ctrl
  import wsi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  wsi_status_t status_i,
  output wsi_cmd_t    cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDiv   = 3'd1;
  localparam logic [2:0] StSetup = 3'd2;
  localparam logic [2:0] StEmit  = 3'd3;
  localparam logic [2:0] StLast  = 3'd4;

  localparam logic [CntBits-1:0] DivLastCnt = CntBits'(CoordBits - 1);

  logic [2:0]         state_q, state_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               have_prev_q, have_prev_d;

  assign in_ready_o = (state_q == StIdle);

  // Next-state and command decode.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    have_prev_d = have_prev_q;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = '0;
          if (have_prev_q && (status_i.points != '0)) begin
            state_d = StDiv;
          end else begin
            state_d = StLast;
          end
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivLastCnt) begin
          state_d = StSetup;
        end
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
        cnt_d       = CntBits'(1);
        state_d     = StEmit;
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit_interp = 1'b1;
          cnt_d             = cnt_q + 1'b1;
          if (cnt_q == CntBits'(status_i.points)) begin
            state_d = StLast;
          end
        end
      end
      StLast: begin
        if (status_i.out_free) begin
          cmd_o.emit_last = 1'b1;
          have_prev_d     = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      have_prev_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      have_prev_q <= have_prev_d;
    end
  end

endmodule

// ----- design/wsi_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsi_datapath
// Per-axis divider, floor-step accumulator, point registers, the
// configuration register and the output register.
// ----------------------------------------------------------------------------
module wsi_datapath
  import wsi_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wsi_cmd_t                      cmd_i,
  output wsi_status_t                   status_o,
  input  logic                          cfg_we_i,
  input  logic [NBits-1:0]              cfg_wdata_i,
  input  logic [NumAxes*CoordBits-1:0]  in_data_i,
  output logic [NumAxes*CoordBits-1:0]  out_data_o,
  output logic                          out_interp_o,
  output logic                          out_last_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i
);

  logic [NBits-1:0]   points_q;
  logic [DivBits-1:0] div_q;

  coord_t             new_q  [NumAxes];
  coord_t             prev_q [NumAxes];
  coord_t             pos_q  [NumAxes];
  coord_t             step_q [NumAxes];
  coord_t             mag_q  [NumAxes];
  logic               neg_q  [NumAxes];
  logic [NBits-1:0]   rem_q  [NumAxes];
  logic [NBits-1:0]   frac_q [NumAxes];
  logic [NBits-1:0]   accr_q [NumAxes];
  coord_t             outc_q [NumAxes];
  logic               out_interp_q, out_last_q, out_valid_q;

  coord_t             in_c      [NumAxes];
  coord_t             mag_init  [NumAxes];
  logic               neg_init  [NumAxes];
  coord_t             mag_next  [NumAxes];
  logic [NBits-1:0]   rem_next  [NumAxes];
  logic [DivBits-1:0] trial     [NumAxes];
  logic [DivBits-1:0] trial_sub [NumAxes];
  coord_t             step_init [NumAxes];
  logic [NBits-1:0]   frac_init [NumAxes];
  logic [DivBits-1:0] frac_sub  [NumAxes];
  logic [DivBits-1:0] acc_sum   [NumAxes];
  logic [DivBits-1:0] acc_sub   [NumAxes];
  logic               carry     [NumAxes];
  logic [NBits-1:0]   accr_next [NumAxes];
  coord_t             pos_next  [NumAxes];

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.points   = points_q;

  // Per-axis arithmetic: magnitude of the delta, one restoring-division
  // step, floor correction of the quotient and the running position.
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      in_c[a]     = in_data_i[a*CoordBits +: CoordBits];
      neg_init[a] = $signed(in_c[a]) < $signed(prev_q[a]);
      mag_init[a] = neg_init[a] ? (prev_q[a] - in_c[a]) : (in_c[a] - prev_q[a]);

      trial[a]     = {rem_q[a], mag_q[a][CoordBits-1]};
      trial_sub[a] = trial[a] - div_q;
      mag_next[a]  = {mag_q[a][CoordBits-2:0], trial[a] >= div_q};
      rem_next[a]  = (trial[a] >= div_q) ? trial_sub[a][NBits-1:0] : trial[a][NBits-1:0];

      // A negative delta with a remainder rounds one further down.
      frac_sub[a] = div_q - {1'b0, rem_q[a]};
      if (!neg_q[a]) begin
        step_init[a] = mag_q[a];
        frac_init[a] = rem_q[a];
      end else if (rem_q[a] == '0) begin
        step_init[a] = -mag_q[a];
        frac_init[a] = '0;
      end else begin
        step_init[a] = ~mag_q[a];
        frac_init[a] = frac_sub[a][NBits-1:0];
      end

      acc_sum[a]   = {1'b0, accr_q[a]} + {1'b0, frac_q[a]};
      acc_sub[a]   = acc_sum[a] - div_q;
      carry[a]     = acc_sum[a] >= div_q;
      accr_next[a] = carry[a] ? acc_sub[a][NBits-1:0] : acc_sum[a][NBits-1:0];
      pos_next[a]  = pos_q[a] + step_q[a] + CoordBits'(carry[a]);

      out_data_o[a*CoordBits +: CoordBits] = outc_q[a];
    end
  end

  assign out_interp_o = out_interp_q;
  assign out_last_o   = out_last_q;
  assign out_valid_o  = out_valid_q;

  // Configuration register and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q    <= PointsBetweenReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        points_q <= cfg_wdata_i;
      end
      if (cmd_i.emit_interp || cmd_i.emit_last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      div_q <= {1'b0, points_q} + DivBits'(1);
    end
    for (int a = 0; a < NumAxes; a++) begin
      if (cmd_i.accept) begin
        new_q[a] <= in_c[a];
        mag_q[a] <= mag_init[a];
        neg_q[a] <= neg_init[a];
        rem_q[a] <= '0;
      end
      if (cmd_i.div_step) begin
        mag_q[a] <= mag_next[a];
        rem_q[a] <= rem_next[a];
      end
      if (cmd_i.setup) begin
        step_q[a] <= step_init[a];
        frac_q[a] <= frac_init[a];
        accr_q[a] <= '0;
        pos_q[a]  <= prev_q[a];
      end
      if (cmd_i.emit_interp) begin
        accr_q[a] <= accr_next[a];
        pos_q[a]  <= pos_next[a];
        outc_q[a] <= pos_next[a];
      end
      if (cmd_i.emit_last) begin
        outc_q[a] <= new_q[a];
        prev_q[a] <= new_q[a];
      end
    end
    if (cmd_i.emit_interp) begin
      out_interp_q <= 1'b1;
      out_last_q   <= 1'b0;
    end
    if (cmd_i.emit_last) begin
      out_interp_q <= 1'b0;
      out_last_q   <= 1'b1;
    end
  end

endmodule

// ----- design/waypoint_segment_interpolator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_segment_interpolator_unit
// Inserts evenly spaced 3D waypoints between consecutive input points.
// ----------------------------------------------------------------------------
// Each accepted item is a new point; if a previous point is held and N (the
// points_between register) is nonzero, the unit emits N inserted points
// prev + floor((new - prev) * i / (N + 1)), i = 1..N, flagged in tuser, then
// the new point itself with tlast. An item passes through these steps:
// accept, CoordBits (32) iterations of the per-axis restoring divider that
// splits the delta into a floor step and a remainder, setup of the
// accumulators, one step per inserted point and one for the new point; the
// emit steps wait while the output register is full. The first point, or
// any point with N = 0, skips the divider and setup. The next item is
// accepted while the final result still waits in the output register.
// ----------------------------------------------------------------------------
module waypoint_segment_interpolator_unit
  import wsi_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration: points_between.
  input  logic                         cfg_we_i,
  input  logic [NBits-1:0]             cfg_wdata_i,
  // Input items.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // tdata: x_coord, y_coord, z_coord (lowest bits first)
  input  logic [NumAxes*CoordBits-1:0] s_axis_tdata_i,
  // Result items.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // tdata: out_x, out_y, out_z (lowest bits first)
  output logic [NumAxes*CoordBits-1:0] m_axis_tdata_o,
  // tuser: is_interpolated
  output logic                         m_axis_tuser_o,
  output logic                         m_axis_tlast_o
);

  wsi_cmd_t    cmd;
  wsi_status_t status;

  // Sequencer.
  wsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  wsi_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_data_i    (s_axis_tdata_i),
    .out_data_o   (m_axis_tdata_o),
    .out_interp_o (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i)
  );

`ifndef SYNTH
  // One item is worked on at a time: after an accept the input side closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while an item is still in work");

  // An inserted point never closes the run of results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> !m_axis_tlast_o)
    else $error("inserted point marked last");

  // The sequencer only issues an emit when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_interp || cmd.emit_last) |-> status.out_free)
    else $error("result overwritten before it was taken");
`endif

endmodule
